@@ rtl/depth_bilateral_filter_5x5_macros.svh @@
// Assertion macros for the depth bilateral filter.
// Needs clk and arst_n in the scope of the module that uses them.
`ifndef DEPTH_BILATERAL_FILTER_5X5_MACROS_SVH
`define DEPTH_BILATERAL_FILTER_5X5_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DBF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("dbf assertion failed");

// Check that cons holds in the cycle after ante.
`define DBF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dbf assertion failed");

`endif

@@ rtl/dbf_pkg.sv @@
// Shared types, constants and the exp table of the depth bilateral filter.
// No dependencies.
package dbf_pkg;

	localparam int ROW_WIDTH   = 320;
	localparam int RADIUS      = 2;
	localparam int WIN         = 2 * RADIUS + 1;
	localparam int LINES       = 2 * RADIUS;
	localparam int PADDED      = ROW_WIDTH + 2 * RADIUS;
	localparam int COL_W       = $clog2(PADDED);
	localparam int EXP_ENTRIES = 256;
	localparam int CFG_IDX_W   = 3;
	localparam logic [95:0] EXP_STEP_Q32 = 96'd4034748382;

	typedef logic [15:0] depth_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SW0,
		CFG_SW1,
		CFG_SW2,
		CFG_SW3,
		CFG_SW4,
		CFG_SIGMA
	} cfg_reg_t;

	typedef logic [15:0] exp_table_t [EXP_ENTRIES];

	// Q0.16 estimate of exp(-k/16), built at elaboration
	function automatic exp_table_t build_exp();
		logic [95:0] acc;
		logic [95:0] v;
		exp_table_t  t;
		acc = 96'd1 << 32;
		for (int k = 0; k < EXP_ENTRIES; k++) begin
			v = (acc + 96'd32768) >> 16;
			t[k] = (v > 96'd65535) ? 16'hFFFF : v[15:0];
			acc = (acc * EXP_STEP_Q32 + (96'd1 << 31)) >> 32;
		end
		return t;
	endfunction

	localparam exp_table_t EXP_TABLE = build_exp();

endpackage

@@ rtl/dbf_if.sv @@
// Stream interfaces for pixel words into and out of the filter.
// Depends on dbf_pkg.
interface dbf_in_if import dbf_pkg::*; ();
	logic   valid;
	logic   ready;
	depth_t depth_sample;
	logic   frame_start;
	modport source (output valid, depth_sample, frame_start, input ready);
	modport sink (input valid, depth_sample, frame_start, output ready);
endinterface

interface dbf_out_if import dbf_pkg::*; ();
	logic   valid;
	logic   ready;
	depth_t filtered_depth;
	logic   last_in_row;
	modport source (output valid, filtered_depth, last_in_row, input ready);
	modport sink (input valid, filtered_depth, last_in_row, output ready);
endinterface

@@ rtl/dbf_ram.sv @@
// Generic single-clock RAM, one write and one registered read port.
// No dependencies.
module dbf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 324,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

@@ rtl/depth_bilateral_filter_5x5.sv @@
// Top level of the 5x5 bilateral filter for depth pixels.
// Depends on dbf_pkg, dbf_if, dbf_ram and the assertion macro header.
//
// Usage: pixel_in takes padded depth words in raster order, PADDED per row;
// frame_start on a word restarts column and row counting with that word.
// Once four rows and four columns of a frame have arrived, each word yields
// one filtered word on pixel_out, last_in_row marking the end of a row.
// cfg_we/cfg_index/cfg_data write the five spatial taps and range sigma;
// write only while idle. Indexes beyond the list are ignored.
// Throughput: one word at a time. A word with no result goes through the
// line store read, then write back and window shift. A word with a result
// then skips each zero neighbour; for each positive one the range exponent
// quotient is clamped or found one bit a cycle, then weighted and summed.
// Then come the final rounded division (one quotient bit a cycle) and load.
// The line store is one RAM of PADDED entries holding the four previous rows
// side by side, read on accept, written back in the cycle after.
// Reset clears counters, window and taps, sets sigma to 100; RAM contents
// stay undefined, and only entries this frame wrote feed a result.
// A stalled receiver holds the output word; the next input word is still
// accepted and worked on, and its result waits until the output is free.
module depth_bilateral_filter_5x5 import dbf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	dbf_in_if.sink               pixel_in,
	dbf_out_if.source            pixel_out,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);
`include "depth_bilateral_filter_5x5_macros.svh"

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_ELEM, S_CLAMP, S_DIV, S_W1, S_W2, S_ACC, S_FINIT, S_FDIV, S_OUT
	} state_t;

	state_t            state_q;
	depth_t            pix_q;
	logic [COL_W-1:0]  col_q;
	logic [COL_W-1:0]  col_cnt_q;
	logic [2:0]        row_cnt_q;
	depth_t            win_q [WIN][WIN];
	depth_t            sw_q [WIN];
	depth_t            sigma_q;
	logic [31:0]       sig2_q;
	logic [2:0]        er_q;
	logic [2:0]        ek_q;
	depth_t            p_q;
	logic [34:0]       n_q;
	logic [34:0]       rem_q;
	logic [7:0]        q_q;
	logic [3:0]        step_q;
	logic [31:0]       spat_q;
	logic [15:0]       w_q;
	logic [31:0]       tp_q;
	logic [20:0]       wsum_q;
	logic [36:0]       tsum_q;
	logic [37:0]       frem_q;
	depth_t            res_q;
	logic              last_q;
	logic              out_valid_q;
	depth_t            out_depth_q;
	logic              out_last_q;

	logic              in_acc;
	logic [COL_W-1:0]  in_col;
	logic [63:0]       ram_rdata;
	logic [63:0]       ram_wdata;
	depth_t            column [WIN];
	logic [COL_W:0]    col_next;
	depth_t            cur_p;
	depth_t            centre;
	depth_t            diff;
	depth_t            sig;
	logic [38:0]       div_trial;
	logic [37:0]       fdiv_trial;

	assign pixel_in.ready = (state_q == S_IDLE);
	assign in_acc = pixel_in.valid && pixel_in.ready;
	assign in_col = (pixel_in.frame_start || (col_cnt_q >= COL_W'(PADDED))) ? '0 : col_cnt_q;

	assign pixel_out.valid          = out_valid_q;
	assign pixel_out.filtered_depth = out_depth_q;
	assign pixel_out.last_in_row    = out_last_q;

	always_comb begin
		for (int r = 0; r < LINES; r++)
			column[r] = ram_rdata[r*16 +: 16];
		column[LINES] = pix_q;
	end
	// row r of the store takes the next younger row
	assign ram_wdata = {column[4], column[3], column[2], column[1]};

	dbf_ram #(.WIDTH(64), .DEPTH(PADDED)) u_line_store (
		.clk   (clk),
		.we    (state_q == S_RD),
		.waddr (col_q),
		.wdata (ram_wdata),
		.re    (in_acc),
		.raddr (in_col),
		.rdata (ram_rdata)
	);

	assign col_next   = {1'b0, col_q} + 1'b1;
	assign cur_p      = win_q[er_q][ek_q];
	assign centre     = win_q[RADIUS][RADIUS];
	assign diff       = (cur_p > centre) ? cur_p - centre : centre - cur_p;
	assign sig        = (sigma_q == '0) ? 16'd1 : sigma_q;
	assign div_trial  = {7'd0, sig2_q} << step_q[2:0];
	assign fdiv_trial = {17'd0, wsum_q} << step_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN; i++)
				sw_q[i] <= '0;
			sigma_q <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SW0, CFG_SW1, CFG_SW2, CFG_SW3, CFG_SW4: sw_q[cfg_index] <= cfg_data;
				CFG_SIGMA: sigma_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pix_q       <= '0;
			col_q       <= '0;
			col_cnt_q   <= '0;
			row_cnt_q   <= '0;
			for (int r = 0; r < WIN; r++)
				for (int k = 0; k < WIN; k++)
					win_q[r][k] <= '0;
			sig2_q      <= '0;
			er_q        <= '0;
			ek_q        <= '0;
			p_q         <= '0;
			n_q         <= '0;
			rem_q       <= '0;
			q_q         <= '0;
			step_q      <= '0;
			spat_q      <= '0;
			w_q         <= '0;
			tp_q        <= '0;
			wsum_q      <= '0;
			tsum_q      <= '0;
			frem_q      <= '0;
			res_q       <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_depth_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			// drop the output word once taken, unless a new one loads now
			if (pixel_out.ready && (state_q != S_OUT))
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						pix_q <= pixel_in.depth_sample;
						col_q <= in_col;
						if (pixel_in.frame_start)
							row_cnt_q <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					// write back is done by the RAM port; shift the window
					for (int r = 0; r < WIN; r++) begin
						for (int k = 0; k < WIN - 1; k++)
							win_q[r][k] <= win_q[r][k+1];
						win_q[r][WIN-1] <= column[r];
					end
					if (col_next >= (COL_W+1)'(PADDED)) begin
						col_cnt_q <= '0;
						if (row_cnt_q < 3'(LINES))
							row_cnt_q <= row_cnt_q + 3'd1;
					end else begin
						col_cnt_q <= col_next[COL_W-1:0];
					end
					sig2_q <= {16'd0, sig} * {16'd0, sig};
					last_q <= (col_q == COL_W'(PADDED - 1));
					er_q   <= '0;
					ek_q   <= '0;
					wsum_q <= '0;
					tsum_q <= '0;
					if ((row_cnt_q >= 3'(LINES)) && (col_q >= COL_W'(LINES)))
						state_q <= S_ELEM;
					else
						state_q <= S_IDLE;
				end
				S_ELEM: begin
					if (centre == '0) begin
						res_q   <= '0;
						state_q <= S_OUT;
					end else if (cur_p == '0) begin
						// skip invalid neighbour
						if (ek_q == 3'(WIN - 1)) begin
							ek_q <= '0;
							if (er_q == 3'(WIN - 1))
								state_q <= S_FINIT;
							else
								er_q <= er_q + 3'd1;
						end else begin
							ek_q <= ek_q + 3'd1;
						end
					end else begin
						n_q     <= {({16'd0, diff} * {16'd0, diff}), 3'd0};
						p_q     <= cur_p;
						spat_q  <= {16'd0, sw_q[ek_q]} * {16'd0, sw_q[er_q]};
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					if ({5'd0, n_q} >= {sig2_q, 8'd0}) begin
						q_q     <= 8'(EXP_ENTRIES - 1);
						state_q <= S_W1;
					end else begin
						rem_q   <= n_q;
						q_q     <= '0;
						step_q  <= 4'd7;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if ({4'd0, rem_q} >= div_trial) begin
						rem_q <= rem_q - div_trial[34:0];
						q_q   <= {q_q[6:0], 1'b1};
					end else begin
						q_q   <= {q_q[6:0], 1'b0};
					end
					if (step_q == '0)
						state_q <= S_W1;
					else
						step_q <= step_q - 4'd1;
				end
				S_W1: begin
					w_q <= 16'(({16'd0, spat_q[31:16]} * {16'd0, EXP_TABLE[q_q]}) >> 16);
					state_q <= S_W2;
				end
				S_W2: begin
					wsum_q  <= wsum_q + {5'd0, w_q};
					tp_q    <= {16'd0, w_q} * {16'd0, p_q};
					state_q <= S_ACC;
				end
				S_ACC: begin
					tsum_q <= tsum_q + {5'd0, tp_q};
					state_q <= S_ELEM;
					if (ek_q == 3'(WIN - 1)) begin
						ek_q <= '0;
						if (er_q == 3'(WIN - 1))
							state_q <= S_FINIT;
						else
							er_q <= er_q + 3'd1;
					end else begin
						ek_q <= ek_q + 3'd1;
					end
				end
				S_FINIT: begin
					if (wsum_q == '0) begin
						res_q   <= '0;
						state_q <= S_OUT;
					end else begin
						// add half the weight to round to nearest
						frem_q  <= {1'b0, tsum_q} + {18'd0, wsum_q[20:1]};
						res_q   <= '0;
						step_q  <= 4'd15;
						state_q <= S_FDIV;
					end
				end
				S_FDIV: begin
					if (frem_q >= fdiv_trial) begin
						frem_q <= frem_q - fdiv_trial;
						res_q  <= {res_q[14:0], 1'b1};
					end else begin
						res_q  <= {res_q[14:0], 1'b0};
					end
					if (step_q == '0)
						state_q <= S_OUT;
					else
						step_q <= step_q - 4'd1;
				end
				S_OUT: begin
					// hold until the output register is free
					if (!out_valid_q || pixel_out.ready) begin
						out_valid_q <= 1'b1;
						out_depth_q <= res_q;
						out_last_q  <= last_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`DBF_ASSERT_NEXT(a_accept_reads, in_acc, state_q == S_RD)
	`DBF_ASSERT_NEXT(a_no_early_result, (state_q == S_RD) && (row_cnt_q < 3'(LINES)), state_q == S_IDLE)
	`DBF_ASSERT(a_div_step, (state_q == S_DIV) |-> (step_q <= 4'd7))
	`DBF_ASSERT(a_elem_index, (er_q <= 3'(WIN - 1)) && (ek_q <= 3'(WIN - 1)))

endmodule
